FILE: rtl/core/erlang_term_stream_parser_unit_macros.svh
// Assertion macros shared by the term stream parser RTL.
`ifndef ERLANG_TERM_STREAM_PARSER_UNIT_MACROS_SVH
`define ERLANG_TERM_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ETSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/etsp_pkg.sv
// Types and codes of the term stream parser.
`timescale 1ns / 1ps

package etsp_pkg;

    typedef logic [3:0] t_event_kind;
    typedef logic [2:0] t_pend_tag;

    localparam t_event_kind K_TUPLE    = 4'd0;
    localparam t_event_kind K_LIST     = 4'd1;
    localparam t_event_kind K_NIL      = 4'd2;
    localparam t_event_kind K_INTEGER  = 4'd3;
    localparam t_event_kind K_ATOM     = 4'd4;
    localparam t_event_kind K_BINARY   = 4'd5;
    localparam t_event_kind K_STRING   = 4'd6;
    localparam t_event_kind K_PAYLOAD  = 4'd7;
    localparam t_event_kind K_BAD_START = 4'd8;
    localparam t_event_kind K_BAD_TAG  = 4'd9;
    localparam t_event_kind K_TOO_DEEP = 4'd10;
    localparam t_event_kind K_TRAILING = 4'd11;

    localparam t_pend_tag P_NONE     = 3'd0;
    localparam t_pend_tag P_SMALLINT = 3'd1;
    localparam t_pend_tag P_INT      = 3'd2;
    localparam t_pend_tag P_ATOM     = 3'd3;
    localparam t_pend_tag P_BINARY   = 3'd4;
    localparam t_pend_tag P_STRING   = 3'd5;
    localparam t_pend_tag P_TUPLE    = 3'd6;
    localparam t_pend_tag P_LIST     = 3'd7;

    localparam logic [7:0] START_BYTE    = 8'd131;
    localparam logic [7:0] TAG_SMALLINT  = 8'd97;
    localparam logic [7:0] TAG_INT       = 8'd98;
    localparam logic [7:0] TAG_ATOM      = 8'd100;
    localparam logic [7:0] TAG_SMALLATOM = 8'd115;
    localparam logic [7:0] TAG_BINARY    = 8'd109;
    localparam logic [7:0] TAG_STRING    = 8'd107;
    localparam logic [7:0] TAG_SMALLTUP  = 8'd104;
    localparam logic [7:0] TAG_LARGETUP  = 8'd105;
    localparam logic [7:0] TAG_NIL       = 8'd106;
    localparam logic [7:0] TAG_LIST      = 8'd108;

endpackage

FILE: rtl/core/erlang_term_stream_parser_unit.sv
// Streaming decoder of binary Erlang terms into token events.
// An event needing no stack walk is in the output register the cycle after its byte transfer.
// A byte that finishes an item walks the child-count stack before its event; each level
// visited takes a RAM read, then a decrement and write back or pop.
// Throughput: one byte per cycle while the output is not stalled and no stack walk runs.
// Reset is synchronous; the stack RAM is not cleared, its entries are pushed first.
`timescale 1ns / 1ps
`include "erlang_term_stream_parser_unit_macros.svh"

module erlang_term_stream_parser_unit #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_byte_value,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output etsp_pkg::t_event_kind o_event_kind,
    output logic [31:0]           o_event_value,
    output logic [4:0]            o_nest_level,
    output logic                  o_term_done
);

    import etsp_pkg::*;

    localparam int SP_W = $clog2(MAX_DEPTH + 1);
    localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_TAG     = 3'd1;
    localparam logic [2:0] PH_SIZE    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_RD   = 2'd1;
    localparam logic [1:0] SEQ_CHK  = 2'd2;

    logic [2:0]      r_phase, n_phase;
    logic [1:0]      r_seq, n_seq;
    t_pend_tag       r_pend, n_pend;
    logic [2:0]      r_sbl, n_sbl;
    logic [31:0]     r_acc, n_acc;
    logic [31:0]     r_pl, n_pl;
    logic [SP_W-1:0] r_sp, n_sp;

    logic            r_out_valid, n_out_valid;
    t_event_kind     r_out_kind, n_out_kind;
    logic [31:0]     r_out_value, n_out_value;
    logic [4:0]      r_out_lvl, n_out_lvl;
    logic            r_out_done, n_out_done;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [32:0]     ram_wdata, ram_rdata;

    logic            in_acc;
    logic [SP_W-1:0] sp_dec;
    logic [SP_W+4:0] sp_ext;
    logic            stack_full;

    assign o_in_stall = !((r_seq == SEQ_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign sp_dec     = r_sp - SP_W'(1);
    assign sp_ext     = (SP_W + 5)'(r_sp);
    assign stack_full = (r_sp == SP_W'(MAX_DEPTH));

    always_comb begin
        logic        do_emit;
        logic        do_close;
        t_event_kind ev_kind;
        logic [31:0] ev_val;
        logic [4:0]  ev_lvl;
        logic [31:0] acc_new;
        logic [2:0]  sbl_new;
        logic [31:0] pl_new;
        logic [32:0] dec;

        n_phase     = r_phase;
        n_seq       = r_seq;
        n_pend      = r_pend;
        n_sbl       = r_sbl;
        n_acc       = r_acc;
        n_pl        = r_pl;
        n_sp        = r_sp;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_lvl   = r_out_lvl;
        n_out_done  = r_out_done;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_sp[AW-1:0];
        ram_raddr   = sp_dec[AW-1:0];
        ram_wdata   = 33'd0;
        do_emit     = 1'b0;
        do_close    = 1'b0;
        ev_kind     = K_NIL;
        ev_val      = 32'd0;
        ev_lvl      = sp_ext[4:0];
        acc_new     = {r_acc[23:0], i_byte_value};
        sbl_new     = (r_sbl != 3'd0) ? (r_sbl - 3'd1) : 3'd0;
        pl_new      = (r_pl != 32'd0) ? (r_pl - 32'd1) : 32'd0;
        dec         = ram_rdata - 33'd1;

        unique case (r_seq)
            SEQ_IDLE: begin
                if (in_acc) begin
                    if (i_frame_start || (r_phase == PH_START)) begin
                        n_sp   = '0;
                        n_pend = P_NONE;
                        n_sbl  = 3'd0;
                        n_acc  = 32'd0;
                        n_pl   = 32'd0;
                        if (i_byte_value != START_BYTE) begin
                            n_phase = PH_ERROR;
                            do_emit = 1'b1;
                            ev_kind = K_BAD_START;
                            ev_val  = {24'd0, i_byte_value};
                            ev_lvl  = 5'd0;
                        end else begin
                            n_phase = PH_TAG;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_TAG: begin
                                n_acc   = 32'd0;
                                n_phase = PH_SIZE;
                                unique case (i_byte_value)
                                    TAG_SMALLINT: begin
                                        n_pend = P_SMALLINT;
                                        n_sbl  = 3'd1;
                                    end
                                    TAG_INT: begin
                                        n_pend = P_INT;
                                        n_sbl  = 3'd4;
                                    end
                                    TAG_ATOM: begin
                                        n_pend = P_ATOM;
                                        n_sbl  = 3'd2;
                                    end
                                    TAG_SMALLATOM: begin
                                        n_pend = P_ATOM;
                                        n_sbl  = 3'd1;
                                    end
                                    TAG_BINARY: begin
                                        n_pend = P_BINARY;
                                        n_sbl  = 3'd4;
                                    end
                                    TAG_STRING: begin
                                        n_pend = P_STRING;
                                        n_sbl  = 3'd2;
                                    end
                                    TAG_SMALLTUP: begin
                                        n_pend = P_TUPLE;
                                        n_sbl  = 3'd1;
                                    end
                                    TAG_LARGETUP: begin
                                        n_pend = P_TUPLE;
                                        n_sbl  = 3'd4;
                                    end
                                    TAG_LIST: begin
                                        n_pend = P_LIST;
                                        n_sbl  = 3'd4;
                                    end
                                    TAG_NIL: begin
                                        n_phase  = r_phase;
                                        do_close = 1'b1;
                                        ev_kind  = K_NIL;
                                    end
                                    default: begin
                                        n_phase = PH_ERROR;
                                        do_emit = 1'b1;
                                        ev_kind = K_BAD_TAG;
                                        ev_val  = {24'd0, i_byte_value};
                                    end
                                endcase
                            end
                            PH_SIZE: begin
                                n_acc = acc_new;
                                n_sbl = sbl_new;
                                ev_val = acc_new;
                                if (sbl_new == 3'd0) begin
                                    case (r_pend) inside
                                        P_SMALLINT, P_INT: begin
                                            do_close = 1'b1;
                                            ev_kind  = K_INTEGER;
                                        end
                                        P_ATOM, P_BINARY, P_STRING: begin
                                            ev_kind = (r_pend == P_ATOM)   ? K_ATOM :
                                                      (r_pend == P_BINARY) ? K_BINARY :
                                                                             K_STRING;
                                            if (acc_new == 32'd0) begin
                                                do_close = 1'b1;
                                            end else begin
                                                do_emit = 1'b1;
                                                n_pl    = acc_new;
                                                n_phase = PH_PAYLOAD;
                                            end
                                        end
                                        P_TUPLE: begin
                                            ev_kind = K_TUPLE;
                                            if (acc_new == 32'd0) begin
                                                do_close = 1'b1;
                                            end else if (stack_full) begin
                                                ev_kind = K_TOO_DEEP;
                                                do_emit = 1'b1;
                                                n_phase = PH_ERROR;
                                            end else begin
                                                do_emit   = 1'b1;
                                                ram_we    = 1'b1;
                                                ram_wdata = {1'b0, acc_new};
                                                n_sp      = r_sp + SP_W'(1);
                                                n_phase   = PH_TAG;
                                            end
                                        end
                                        default: begin
                                            // A list counts its elements and its tail.
                                            do_emit = 1'b1;
                                            if (stack_full) begin
                                                ev_kind = K_TOO_DEEP;
                                                n_phase = PH_ERROR;
                                            end else begin
                                                ev_kind   = K_LIST;
                                                ram_we    = 1'b1;
                                                ram_wdata = {1'b0, acc_new} + 33'd1;
                                                n_sp      = r_sp + SP_W'(1);
                                                n_phase   = PH_TAG;
                                            end
                                        end
                                    endcase
                                end
                            end
                            PH_PAYLOAD: begin
                                n_pl    = pl_new;
                                ev_kind = K_PAYLOAD;
                                ev_val  = {24'd0, i_byte_value};
                                if (pl_new == 32'd0) begin
                                    do_close = 1'b1;
                                end else begin
                                    do_emit = 1'b1;
                                end
                            end
                            PH_DONE: begin
                                do_emit = 1'b1;
                                ev_kind = K_TRAILING;
                                ev_val  = {24'd0, i_byte_value};
                            end
                            default: begin
                            end
                        endcase
                    end

                    if (do_emit || do_close) begin
                        n_out_kind  = ev_kind;
                        n_out_value = ev_val;
                        n_out_lvl   = ev_lvl;
                        n_out_done  = 1'b0;
                    end
                    if (do_emit) begin
                        n_out_valid = 1'b1;
                    end
                    if (do_close) begin
                        if (r_sp == '0) begin
                            n_out_valid = 1'b1;
                            n_out_done  = 1'b1;
                            n_phase     = PH_DONE;
                        end else begin
                            n_seq = SEQ_RD;
                        end
                    end
                end
            end
            SEQ_RD: begin
                ram_re = 1'b1;
                n_seq  = SEQ_CHK;
            end
            SEQ_CHK: begin
                if (dec != 33'd0) begin
                    // The open container still has children to come.
                    ram_we      = 1'b1;
                    ram_waddr   = sp_dec[AW-1:0];
                    ram_wdata   = dec;
                    n_phase     = PH_TAG;
                    n_out_valid = 1'b1;
                    n_out_done  = 1'b0;
                    n_seq       = SEQ_IDLE;
                end else begin
                    n_sp = sp_dec;
                    if (sp_dec == '0) begin
                        n_phase     = PH_DONE;
                        n_out_valid = 1'b1;
                        n_out_done  = 1'b1;
                        n_seq       = SEQ_IDLE;
                    end else begin
                        n_seq = SEQ_RD;
                    end
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_seq       <= SEQ_IDLE;
            r_pend      <= P_NONE;
            r_sbl       <= 3'd0;
            r_acc       <= 32'd0;
            r_pl        <= 32'd0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_pend      <= n_pend;
            r_sbl       <= n_sbl;
            r_acc       <= n_acc;
            r_pl        <= n_pl;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_lvl   <= n_out_lvl;
        r_out_done  <= n_out_done;
    end

    etsp_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (33)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_event_value = r_out_value;
    assign o_nest_level  = r_out_lvl;
    assign o_term_done   = r_out_done;

    `ETSP_ASSERT_IMP(a_busy_stalls, r_seq != SEQ_IDLE, o_in_stall, "transfer taken while closing")
    `ETSP_ASSERT_IMP(a_sp_bound, 1'b1, r_sp <= SP_W'(MAX_DEPTH), "stack pointer past depth")
    `ETSP_ASSERT_IMP(a_close_no_out, r_seq != SEQ_IDLE, !r_out_valid, "event shown mid-close")
    `ETSP_ASSERT_IMP(a_done_kind, r_out_valid && r_out_done, r_out_kind <= K_PAYLOAD,
        "term done on an error event")
    `ETSP_ASSERT_NXT(a_rd_then_chk, r_seq == SEQ_RD, r_seq == SEQ_CHK, "stack read not checked")

endmodule

FILE: rtl/core/etsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module etsp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 33,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
